// ===== design/coap_message_serializer_defines.svh =====
// assertion macros for the coap message serializer
// no dependencies; included by coap_message_serializer, which checks its own logic
`ifndef COAP_MESSAGE_SERIALIZER_DEFINES_SVH
`define COAP_MESSAGE_SERIALIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define CMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cms assertion failed");

`define CMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cms assertion failed");

`else

`define CMS_ASSERT(lbl, clk, rst_n, prop)

`define CMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/cms_pkg.sv =====
// shared types and constants of the coap message serializer
// no dependencies
package cms_pkg;

    localparam int unsigned MAX_TOKEN_BYTES = 8;
    localparam int unsigned MAX_RESULTS     = 5;
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam int unsigned QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RIDX_W          = $clog2(MAX_RESULTS);

    localparam logic [2:0] ACT_START     = 3'd0;
    localparam logic [2:0] ACT_TOKEN     = 3'd1;
    localparam logic [2:0] ACT_OPT_BEGIN = 3'd2;
    localparam logic [2:0] ACT_OPT_DATA  = 3'd3;
    localparam logic [2:0] ACT_PAYLOAD   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ROOM  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;
    localparam logic [15:0] HEADER_BYTES   = 16'd4;
    localparam logic [15:0] EXT8_BASE      = 16'd13;
    localparam logic [15:0] EXT16_BASE     = 16'd269;
    localparam logic [3:0]  EXT8_CODE      = 4'd13;
    localparam logic [3:0]  EXT16_CODE     = 4'd14;
    localparam logic [3:0]  NIBBLE_MASK    = 4'hF;
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [1:0]  COAP_VERSION   = 2'd1;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  mtype;
        logic [7:0]  code;
        logic [15:0] mid;
        logic [3:0]  tkl;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [2:0]                  count;
        logic [1:0]                  status;
    } t_bundle;

endpackage

// ===== design/cms_ifs.sv =====
// valid/ready channel interfaces of the coap message serializer
// no dependencies
interface cms_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [1:0]  mtype;
    logic [7:0]  code;
    logic [15:0] mid;
    logic [3:0]  tkl;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [7:0]  data_byte;

    modport source (
        output valid, action, mtype, code, mid, tkl,
               option_number, option_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, action, mtype, code, mid, tkl,
               option_number, option_length, data_byte,
        output ready
    );
endinterface

interface cms_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_result;
    logic [1:0] status;

    modport source (
        output valid, out_byte, byte_valid, last_result, status,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, last_result, status,
        output ready
    );
endinterface

// ===== design/cms_encoder.sv =====
// message state and per-item rule checks; builds the result bytes of one item
// depends on cms_pkg
module cms_encoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data,
    input  logic             i_take,
    input  cms_pkg::t_item   i_item,
    output cms_pkg::t_bundle o_bundle
);

    typedef struct packed {
        logic [1:0] size;
        logic [7:0] first;
        logic [7:0] second;
    } t_ext;

    function automatic t_ext ext_of(input logic [15:0] v);
        t_ext       e;
        logic [15:0] d;
        e = '0;
        d = v - cms_pkg::EXT16_BASE;
        if (v >= cms_pkg::EXT16_BASE) begin
            e.size   = 2'd2;
            e.first  = d[15:8];
            e.second = d[7:0];
        end else if (v >= cms_pkg::EXT8_BASE) begin
            d       = v - cms_pkg::EXT8_BASE;
            e.size  = 2'd1;
            e.first = d[7:0];
        end
        return e;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [15:0] v);
        logic [3:0] n;
        if (v >= cms_pkg::EXT16_BASE) begin
            n = cms_pkg::EXT16_CODE;
        end else if (v >= cms_pkg::EXT8_BASE) begin
            n = cms_pkg::EXT8_CODE;
        end else begin
            n = v[3:0] & cms_pkg::NIBBLE_MASK;
        end
        return n;
    endfunction

    logic [15:0] r_capacity;
    logic [15:0] r_used;
    logic        r_marker;
    logic [15:0] r_prev;
    logic        r_empty;
    logic [3:0]  r_tok_left;
    logic [15:0] r_opt_left;

    logic [15:0] n_used;
    logic        n_marker;
    logic [15:0] n_prev;
    logic        n_empty;
    logic [3:0]  n_tok_left;
    logic [15:0] n_opt_left;

    logic [16:0] room_diff;
    logic [15:0] room;
    logic [15:0] start_need;
    logic [15:0] delta;
    t_ext        dx;
    t_ext        lx;
    logic [2:0]  hsize;
    logic [16:0] opt_need;
    logic [1:0]  st;
    logic [2:0]  cnt;
    logic [cms_pkg::MAX_RESULTS-1:0][7:0] bytes;

    assign room_diff  = {1'b0, r_capacity} - {1'b0, r_used};
    assign room       = room_diff[16] ? 16'd0 : room_diff[15:0];
    assign start_need = cms_pkg::HEADER_BYTES + {12'd0, i_item.tkl};
    assign delta      = i_item.option_number - r_prev;
    assign dx         = ext_of(delta);
    assign lx         = ext_of(i_item.option_length);
    assign hsize      = 3'd1 + {1'b0, dx.size} + {1'b0, lx.size};
    assign opt_need   = {14'd0, hsize} + {1'b0, i_item.option_length};

    always_comb begin
        st         = cms_pkg::ST_OK;
        cnt        = 3'd1;
        bytes      = '0;
        n_used     = r_used;
        n_marker   = r_marker;
        n_prev     = r_prev;
        n_empty    = r_empty;
        n_tok_left = r_tok_left;
        n_opt_left = r_opt_left;

        if (i_item.action == cms_pkg::ACT_START) begin
            priority if (i_item.tkl > 4'(cms_pkg::MAX_TOKEN_BYTES)) begin
                st = cms_pkg::ST_ORDER;
            end else if (i_item.code == 8'd0 && i_item.tkl != 4'd0) begin
                st = cms_pkg::ST_EMPTY;
            end else if (start_need > r_capacity) begin
                st = cms_pkg::ST_ROOM;
            end else begin
                bytes[0]   = {cms_pkg::COAP_VERSION, i_item.mtype, i_item.tkl};
                bytes[1]   = i_item.code;
                bytes[2]   = i_item.mid[15:8];
                bytes[3]   = i_item.mid[7:0];
                cnt        = 3'd4;
                n_used     = cms_pkg::HEADER_BYTES;
                n_marker   = 1'b0;
                n_prev     = 16'd0;
                n_empty    = (i_item.code == 8'd0);
                n_tok_left = i_item.tkl;
                n_opt_left = 16'd0;
            end
        end else if (r_used == 16'd0 || i_item.action > cms_pkg::ACT_PAYLOAD) begin
            st = cms_pkg::ST_ORDER;
        end else begin
            unique case (i_item.action)
                cms_pkg::ACT_TOKEN: begin
                    priority if (r_tok_left == 4'd0) begin
                        st = cms_pkg::ST_ORDER;
                    end else if (room == 16'd0) begin
                        st = cms_pkg::ST_ROOM;
                    end else begin
                        bytes[0]   = i_item.data_byte;
                        n_used     = r_used + 16'd1;
                        n_tok_left = r_tok_left - 4'd1;
                    end
                end
                cms_pkg::ACT_OPT_BEGIN: begin
                    priority if (r_tok_left != 4'd0 || r_opt_left != 16'd0 || r_marker ||
                                 i_item.option_number < r_prev) begin
                        st = cms_pkg::ST_ORDER;
                    end else if (r_empty) begin
                        st = cms_pkg::ST_EMPTY;
                    end else if (opt_need > {1'b0, room}) begin
                        st = cms_pkg::ST_ROOM;
                    end else begin
                        bytes[0] = {nibble_of(delta), nibble_of(i_item.option_length)};
                        unique case (dx.size)
                            2'd0: begin
                                bytes[1] = lx.first;
                                bytes[2] = lx.second;
                            end
                            2'd1: begin
                                bytes[1] = dx.first;
                                bytes[2] = lx.first;
                                bytes[3] = lx.second;
                            end
                            default: begin
                                bytes[1] = dx.first;
                                bytes[2] = dx.second;
                                bytes[3] = lx.first;
                                bytes[4] = lx.second;
                            end
                        endcase
                        cnt        = hsize;
                        n_used     = r_used + {13'd0, hsize};
                        n_opt_left = i_item.option_length;
                        n_prev     = i_item.option_number;
                    end
                end
                cms_pkg::ACT_OPT_DATA: begin
                    priority if (r_opt_left == 16'd0) begin
                        st = cms_pkg::ST_ORDER;
                    end else if (room == 16'd0) begin
                        st = cms_pkg::ST_ROOM;
                    end else begin
                        bytes[0]   = i_item.data_byte;
                        n_used     = r_used + 16'd1;
                        n_opt_left = r_opt_left - 16'd1;
                    end
                end
                default: begin
                    priority if (r_tok_left != 4'd0 || r_opt_left != 16'd0) begin
                        st = cms_pkg::ST_ORDER;
                    end else if (room < (r_marker ? 16'd1 : 16'd2)) begin
                        st = cms_pkg::ST_ROOM;
                    end else if (!r_marker) begin
                        bytes[0] = cms_pkg::PAYLOAD_MARKER;
                        bytes[1] = i_item.data_byte;
                        cnt      = 3'd2;
                        n_used   = r_used + 16'd2;
                        n_marker = 1'b1;
                    end else begin
                        bytes[0] = i_item.data_byte;
                        n_used   = r_used + 16'd1;
                    end
                end
            endcase
        end

        if (st != cms_pkg::ST_OK) begin
            bytes = '0;
            cnt   = 3'd1;
        end
    end

    assign o_bundle.bytes  = bytes;
    assign o_bundle.count  = cnt;
    assign o_bundle.status = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= cms_pkg::CAPACITY_RESET;
            r_used     <= 16'd0;
            r_marker   <= 1'b0;
            r_prev     <= 16'd0;
            r_empty    <= 1'b0;
            r_tok_left <= 4'd0;
            r_opt_left <= 16'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_take && st == cms_pkg::ST_OK) begin
                r_used     <= n_used;
                r_marker   <= n_marker;
                r_prev     <= n_prev;
                r_empty    <= n_empty;
                r_tok_left <= n_tok_left;
                r_opt_left <= n_opt_left;
            end
        end
    end

endmodule

// ===== design/coap_message_serializer.sv =====
// Serializes one CoAP message (RFC 7252 framing) from a stream of items:
// start, token byte, option begin, option data byte, payload byte. Each
// accepted item yields one to five result transactions, one per cycle on the
// output channel while the sink is ready: a start gives four header bytes, an
// option begin one to five option header bytes, a data byte one byte, and the
// first payload byte two (marker and byte); a rejected item gives a single
// result with byte_valid low and a status, and leaves the message state
// untouched. Items pass an input register and are checked combinationally
// against the message state; their result bytes go into a two-entry result
// queue, so a new item is accepted every cycle as long as the queue has room.
// The output drains one byte per cycle while the sink is ready, so the
// sustained rate is one item per cycle for single-byte items. The first
// result of an item passes the input register and the result queue before it
// is presented. The byte budget resets to 1024 and the user must write it
// through the configuration port while the block is idle; nothing checks it.
// depends on cms_pkg, cms_ifs, cms_encoder and the assertion macro header
`include "coap_message_serializer_defines.svh"

module coap_message_serializer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    cms_item_if.sink     i_item,
    cms_result_if.source o_result
);

    logic                           r_in_valid;
    cms_pkg::t_item                 r_in;
    cms_pkg::t_bundle               enc_bundle;
    cms_pkg::t_bundle               r_q [cms_pkg::QUEUE_DEPTH];
    logic [cms_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [cms_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [cms_pkg::QCNT_W-1:0]     r_q_cnt;
    logic [cms_pkg::RIDX_W-1:0]     r_idx;
    cms_pkg::t_bundle               head;
    logic                           q_room;
    logic                           take;
    logic                           out_fire;
    logic                           last;
    logic                           pop;

    assign q_room       = (r_q_cnt != cms_pkg::QCNT_W'(cms_pkg::QUEUE_DEPTH));
    assign take         = r_in_valid && q_room;
    assign i_item.ready = !r_in_valid || q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.action        <= i_item.action;
            r_in.mtype         <= i_item.mtype;
            r_in.code          <= i_item.code;
            r_in.mid           <= i_item.mid;
            r_in.tkl           <= i_item.tkl;
            r_in.option_number <= i_item.option_number;
            r_in.option_length <= i_item.option_length;
            r_in.data_byte     <= i_item.data_byte;
        end
    end

    cms_encoder u_encoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_take        (take),
        .i_item        (r_in),
        .o_bundle      (enc_bundle)
    );

    assign head     = r_q[r_rd_ptr];
    assign last     = ({1'b0, r_idx} == 4'(head.count) - 4'd1);
    assign out_fire = o_result.valid && o_result.ready;
    assign pop      = out_fire && last;

    assign o_result.valid       = (r_q_cnt != '0);
    assign o_result.out_byte    = head.bytes[r_idx];
    assign o_result.byte_valid  = (head.status == cms_pkg::ST_OK);
    assign o_result.last_result = last;
    assign o_result.status      = head.status;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wr_ptr] <= enc_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
            r_idx    <= '0;
        end else begin
            if (take) begin
                r_wr_ptr <= (r_wr_ptr == cms_pkg::QPTR_W'(cms_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == cms_pkg::QPTR_W'(cms_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            r_q_cnt <= r_q_cnt + cms_pkg::QCNT_W'(take) - cms_pkg::QCNT_W'(pop);
            if (out_fire) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end
        end
    end

    `CMS_ASSERT(a_queue_bound, i_clk, i_rst_n, r_q_cnt <= cms_pkg::QCNT_W'(cms_pkg::QUEUE_DEPTH))
    `CMS_ASSERT(a_idx_bound, i_clk, i_rst_n, o_result.valid |-> ({1'b0, r_idx} < 4'(head.count)))
    `CMS_ASSERT(a_reject_single, i_clk, i_rst_n,
                (o_result.valid && !o_result.byte_valid) |-> (last && r_idx == '0))
    `CMS_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n, take, r_q_cnt != '0)

endmodule
